>>> src/fcd_pkg.sv
// Shared types, codes and helper functions for the framed command decoder.
// No dependencies; every other RTL file except fcd_ram refers to it by scoped names.
package fcd_pkg;

    // Defaults for the top-level parameters
    localparam int FRAME_DEPTH_DEF = 12;
    localparam int TICK_WIDTH_DEF  = 16;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int VALUE_W    = 10;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_JET_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ON_SPEED  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [15:0] JET_TICKS_RST = 16'd200;
    localparam logic [7:0]  ON_SPEED_RST  = 8'd250;
    localparam logic [7:0]  LOW_LIMIT_RST = 8'd50;

    // Value limits
    localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd999;
    localparam logic [VALUE_W-1:0] SPEED_MAX = 10'd255;

    // Protocol characters
    localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
    localparam logic [7:0] CH_O    = 8'h6F;  // 'o'
    localparam logic [7:0] CH_C    = 8'h63;  // 'c'
    localparam logic [7:0] CH_J    = 8'h6A;  // 'j'
    localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE = 8'h39;  // '9'

    typedef enum logic [3:0] {
        ST_NONE    = 4'd0,
        ST_ON      = 4'd1,
        ST_OFF     = 4'd2,
        ST_SPEED   = 4'd3,
        ST_HIGH    = 4'd4,
        ST_LOW     = 4'd5,
        ST_JET     = 4'd6,
        ST_BADJET  = 4'd7,
        ST_UNKNOWN = 4'd8,
        ST_CHECK   = 4'd9,
        ST_FRAME   = 4'd10
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_DRAIN,
        FSM_EXEC
    } fsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;   // input word accepted this cycle
        logic walk;   // issue a frame buffer read this cycle
        logic exec;   // evaluate the walked frame and load the result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a word
        logic walk_start;  // word at the input closes a frame that needs a walk
        logic walk_last;   // current read address is the last buffered byte
    } ctrl_sts_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [3:0] digit_val(input logic [7:0] b);
        logic [7:0] d;
        d = b - CH_ZERO;
        digit_val = d[3:0];
    endfunction

    // Reduce a running sum below 400 to its value mod 100
    function automatic logic [6:0] mod100(input logic [8:0] x);
        logic [8:0] r;
        if (x >= 9'd300) begin
            r = x - 9'd300;
        end else if (x >= 9'd200) begin
            r = x - 9'd200;
        end else if (x >= 9'd100) begin
            r = x - 9'd100;
        end else begin
            r = x;
        end
        mod100 = r[6:0];
    endfunction

endpackage

>>> src/fcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fcd_datapath.sv
// Datapath of the framed command decoder: frame buffer, checksum and argument
// accumulators, conveyor and jet state, config registers, output register.
// Depends on fcd_pkg and fcd_ram.
module fcd_datapath #(
    parameter int FRAME_DEPTH = fcd_pkg::FRAME_DEPTH_DEF,
    parameter int TICK_WIDTH  = fcd_pkg::TICK_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [fcd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [fcd_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fcd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fcd_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [fcd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fcd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  fcd_pkg::ctrl_cmd_t              cmd,
    output fcd_pkg::ctrl_sts_t              sts
);

    localparam int ADDR_W    = $clog2(FRAME_DEPTH);
    localparam int LEN_W     = $clog2(FRAME_DEPTH + 1);
    localparam int VALUE_W_L = fcd_pkg::VALUE_W;

    // Configuration
    logic [15:0] jet_ticks_reg;
    logic [7:0]  on_speed_reg;
    logic [7:0]  low_limit_reg;

    // Frame capture
    logic             cap_reg, cap_next;
    logic             ovf_reg, ovf_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             buf_we;
    logic [7:0]       buf_rdata;

    // Conveyor and jets
    logic                  belt_on_reg, belt_on_next;
    logic [7:0]            speed_reg, speed_next;
    logic [TICK_WIDTH-1:0] jet_cnt_reg [2];
    logic [TICK_WIDTH-1:0] jet_cnt_next [2];
    logic [TICK_WIDTH+15:0] jet_ticks_wide;
    logic [TICK_WIDTH-1:0] jet_reload;

    // Frame walk
    logic [LEN_W-1:0]   rd_idx_reg;
    logic               proc_vld_reg;
    logic [LEN_W-1:0]   proc_idx_reg;
    logic [LEN_W-1:0]   body_len;
    logic [6:0]         sum_reg, sum_next;
    logic [VALUE_W_L-1:0] arg_reg, arg_next;
    logic               arg_run_reg, arg_run_next;
    logic [7:0]         cmd_byte_reg;
    logic [7:0]         hi_reg;
    logic [7:0]         lo_reg;
    logic [13:0]        arg_prod;
    logic [6:0]         check_val;
    logic               check_ok;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic                  load;
    fcd_pkg::status_t      status_next;
    logic [VALUE_W_L-1:0]  value_next;
    fcd_pkg::status_t      out_status_reg;
    logic [VALUE_W_L-1:0]  out_value_reg;
    logic                  out_on_reg;
    logic [7:0]            out_speed_reg;
    logic                  out_j0_reg;
    logic                  out_j1_reg;

    logic       func;
    logic [7:0] rx;

    assign func = s_tuser[0];
    assign rx   = s_tdata[7:0];

    assign jet_ticks_wide = {{TICK_WIDTH{1'b0}}, jet_ticks_reg};
    assign jet_reload     = jet_ticks_wide[TICK_WIDTH-1:0];
    assign body_len       = len_reg - LEN_W'(2);

    assign sts.walk_start = !func && (rx == fcd_pkg::CH_GT) && cap_reg && !ovf_reg
                            && (len_reg >= LEN_W'(3));
    assign sts.walk_last  = (rd_idx_reg == len_reg - LEN_W'(1));
    assign sts.out_free   = !m_valid_reg || m_tready;

    fcd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (rx),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (buf_rdata)
    );

    // Accumulate one buffered byte per cycle while the walk runs
    always_comb begin
        sum_next     = sum_reg;
        arg_next     = arg_reg;
        arg_run_next = arg_run_reg;
        arg_prod     = 14'(arg_reg) * 14'd10 + 14'(fcd_pkg::digit_val(buf_rdata));
        if (cmd.take) begin
            sum_next     = '0;
            arg_next     = '0;
            arg_run_next = 1'b1;
        end else if (proc_vld_reg) begin
            if (proc_idx_reg < body_len) begin
                sum_next = fcd_pkg::mod100({2'b00, sum_reg} + {1'b0, buf_rdata});
                if (proc_idx_reg != '0 && arg_run_reg) begin
                    if (fcd_pkg::is_digit(buf_rdata)) begin
                        arg_next = (arg_prod > 14'(fcd_pkg::VALUE_MAX))
                                   ? fcd_pkg::VALUE_MAX : arg_prod[VALUE_W_L-1:0];
                    end else begin
                        arg_run_next = 1'b0;
                    end
                end
            end
        end
    end

    assign check_val = 7'({3'b000, fcd_pkg::digit_val(hi_reg)} * 7'd10)
                       + {3'b000, fcd_pkg::digit_val(lo_reg)};
    assign check_ok  = fcd_pkg::is_digit(hi_reg) && fcd_pkg::is_digit(lo_reg)
                       && (check_val == sum_reg);

    // Item handling, command execution and result selection
    always_comb begin
        cap_next     = cap_reg;
        ovf_next     = ovf_reg;
        len_next     = len_reg;
        belt_on_next = belt_on_reg;
        speed_next   = speed_reg;
        jet_cnt_next = jet_cnt_reg;
        buf_we       = 1'b0;
        load         = 1'b0;
        status_next  = fcd_pkg::ST_NONE;
        value_next   = '0;

        if (cmd.take) begin
            load = !sts.walk_start;
            if (func) begin
                for (int k = 0; k < 2; k++) begin
                    if (jet_cnt_reg[k] != '0) begin
                        jet_cnt_next[k] = jet_cnt_reg[k] - TICK_WIDTH'(1);
                    end
                end
            end else if (rx == fcd_pkg::CH_LT) begin
                cap_next = 1'b1;
                len_next = '0;
                ovf_next = 1'b0;
            end else if (rx == fcd_pkg::CH_GT) begin
                cap_next    = 1'b0;
                status_next = fcd_pkg::ST_FRAME;
            end else if (cap_reg) begin
                if (len_reg < LEN_W'(FRAME_DEPTH)) begin
                    buf_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end

        if (cmd.exec) begin
            load = 1'b1;
            if (!check_ok) begin
                status_next = fcd_pkg::ST_CHECK;
            end else begin
                value_next = arg_reg;
                unique case (cmd_byte_reg)
                    fcd_pkg::CH_O: begin
                        belt_on_next = !belt_on_reg;
                        speed_next   = belt_on_reg ? 8'd0 : on_speed_reg;
                        status_next  = belt_on_reg ? fcd_pkg::ST_OFF : fcd_pkg::ST_ON;
                    end
                    fcd_pkg::CH_C: begin
                        if (arg_reg > fcd_pkg::SPEED_MAX) begin
                            speed_next  = 8'hFF;
                            status_next = fcd_pkg::ST_HIGH;
                        end else begin
                            speed_next  = arg_reg[7:0];
                            status_next = (arg_reg < {2'b00, low_limit_reg})
                                          ? fcd_pkg::ST_LOW : fcd_pkg::ST_SPEED;
                        end
                    end
                    fcd_pkg::CH_J: begin
                        if (arg_reg > VALUE_W_L'(1)) begin
                            status_next = fcd_pkg::ST_BADJET;
                        end else begin
                            jet_cnt_next[arg_reg[0]] = jet_reload;
                            status_next = fcd_pkg::ST_JET;
                        end
                    end
                    default: begin
                        status_next = fcd_pkg::ST_UNKNOWN;
                    end
                endcase
            end
        end

        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jet_ticks_reg   <= fcd_pkg::JET_TICKS_RST;
            on_speed_reg    <= fcd_pkg::ON_SPEED_RST;
            low_limit_reg   <= fcd_pkg::LOW_LIMIT_RST;
            cap_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            len_reg         <= '0;
            belt_on_reg     <= 1'b0;
            speed_reg       <= '0;
            jet_cnt_reg[0]  <= '0;
            jet_cnt_reg[1]  <= '0;
            proc_vld_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    fcd_pkg::CFG_JET_TICKS: jet_ticks_reg <= cfg_wdata;
                    fcd_pkg::CFG_ON_SPEED:  on_speed_reg  <= cfg_wdata[7:0];
                    fcd_pkg::CFG_LOW_LIMIT: low_limit_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            cap_reg        <= cap_next;
            ovf_reg        <= ovf_next;
            len_reg        <= len_next;
            belt_on_reg    <= belt_on_next;
            speed_reg      <= speed_next;
            jet_cnt_reg[0] <= jet_cnt_next[0];
            jet_cnt_reg[1] <= jet_cnt_next[1];
            proc_vld_reg   <= cmd.walk;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Walk datapath and output payload need no reset
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            rd_idx_reg <= '0;
        end else if (cmd.walk) begin
            rd_idx_reg <= rd_idx_reg + LEN_W'(1);
        end
        proc_idx_reg <= rd_idx_reg;
        sum_reg      <= sum_next;
        arg_reg      <= arg_next;
        arg_run_reg  <= arg_run_next;
        if (proc_vld_reg) begin
            if (proc_idx_reg == '0) begin
                cmd_byte_reg <= buf_rdata;
            end
            if (proc_idx_reg == body_len) begin
                hi_reg <= buf_rdata;
            end
            if (proc_idx_reg == len_reg - LEN_W'(1)) begin
                lo_reg <= buf_rdata;
            end
        end
        if (load) begin
            out_status_reg <= status_next;
            out_value_reg  <= value_next;
            out_on_reg     <= belt_on_next;
            out_speed_reg  <= speed_next;
            out_j0_reg     <= (jet_cnt_next[0] != '0);
            out_j1_reg     <= (jet_cnt_next[1] != '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_j1_reg, out_j0_reg, out_speed_reg, out_on_reg,
                       out_value_reg};

endmodule

>>> src/fcd_ctrl.sv
// Controller of the framed command decoder: accepts words and sequences the
// frame buffer walk at the end of a frame. Depends on fcd_pkg.
module fcd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fcd_pkg::ctrl_sts_t  sts,
    output fcd_pkg::ctrl_cmd_t  cmd
);

    fcd_pkg::fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcd_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            fcd_pkg::FSM_IDLE: begin
                s_tready = sts.out_free;
                cmd.take = s_tvalid && sts.out_free;
                if (cmd.take && sts.walk_start) begin
                    state_next = fcd_pkg::FSM_WALK;
                end
            end
            fcd_pkg::FSM_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_last) begin
                    state_next = fcd_pkg::FSM_DRAIN;
                end
            end
            fcd_pkg::FSM_DRAIN: begin
                state_next = fcd_pkg::FSM_EXEC;
            end
            fcd_pkg::FSM_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = fcd_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

>>> src/framed_command_decoder_jet_control.sv
// Top level of the framed command decoder for a conveyor and two air jets.
// Depends on fcd_pkg, fcd_ctrl and fcd_datapath.
//
//   Input stream (s_): each word is a received serial byte or, with s_tuser
//   set, a one-millisecond tick. Every accepted word yields exactly one
//   result word (m_): status in m_tuser, argument and conveyor and jet state
//   in m_tdata. Bytes between '<' and '>' fill a FRAME_DEPTH-byte buffer; a
//   '>' closing a frame of n >= 3 buffered bytes that did not overflow walks
//   the buffer one byte per cycle to check the two decimal check digits
//   against the byte sum mod 100 and to decode the command.
//   Timing: a tick or an ordinary byte is registered into the output in the
//   cycle after it is taken; a walked frame end first passes the WALK, DRAIN and EXEC states.
//   Throughput: one word per cycle while m_tready stays high and no frame is
//   walked; after a walked '>' s_tready stays low in the WALK, DRAIN and EXEC states.
//   Stalls: the output register holds a result until taken; a new word is
//   accepted in the cycle the held result leaves, otherwise s_tready is low.
//   Reset (aresetn, synchronous, active low) closes any open frame, stops
//   the conveyor and both jets, empties the output register and reloads the
//   config registers (200 ticks, speed 250, limit 50). Write config through
//   cfg_wr_en/cfg_addr/cfg_wdata only while no word is in flight.
module framed_command_decoder_jet_control #(
    parameter int FRAME_DEPTH = fcd_pkg::FRAME_DEPTH_DEF,
    parameter int TICK_WIDTH  = fcd_pkg::TICK_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fcd_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic [fcd_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] func (1 = tick)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] cmd_value, [10] conveyor_on, [18:11] speed_pwm, [19] jet0_drive,
    // [20] jet1_drive, [23:21] zero
    output logic [fcd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fcd_pkg::M_TUSER_W-1:0]   m_tuser,   // [3:0] status
    input  logic                            cfg_wr_en,
    input  logic [fcd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fcd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    fcd_pkg::ctrl_cmd_t cmd;
    fcd_pkg::ctrl_sts_t sts;

    // Sequence word acceptance and the buffer walk
    fcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold frame, conveyor and jet state; build the result word
    fcd_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A stalled result blocks the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while a result is stalled");

    // An accepted tick reports status none in the next cycle
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0])
        |=> (m_tvalid && m_tuser == fcd_pkg::ST_NONE))
        else $error("tick did not produce its result");

    // The output register is empty when a walked frame is evaluated
    a_exec_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |-> !m_tvalid)
        else $error("frame result would overwrite a pending word");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for framed_command_decoder_jet_control.
// Needs fcd_pkg and the decoder RTL. Frames, ticks and noise words are sent
// on the input stream, and every result word is compared with a local decode.
module testbench;

    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 24;       // longer than the longest frame walk
    localparam int STALL_CYCLES  = 400;      // long receiver hold-off
    localparam int PHASE_WORDS   = 110;      // minimum live random words per idling phase
    localparam int TIMEOUT_UNITS = 5000000;

    // How the check digits of a generated frame are formed
    typedef enum logic [1:0] {
        CHK_GOOD,
        CHK_WRONG,
        CHK_NONDIGIT
    } check_mode_t;

    // One decoded result word, split into its fields
    typedef struct packed {
        fcd_pkg::status_t status;
        logic [9:0]       value;
        logic             belt;
        logic [7:0]       speed;
        logic             jet0;
        logic             jet1;
    } decoder_out_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [fcd_pkg::S_TDATA_W-1:0]    s_tdata   = '0;
    logic [fcd_pkg::S_TUSER_W-1:0]    s_tuser   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [fcd_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [fcd_pkg::M_TUSER_W-1:0]    m_tuser;
    logic                             cfg_wr_en = 1'b0;
    logic [fcd_pkg::CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // Local copy of the decoder state and its registers
    logic [7:0]   frame_mem [fcd_pkg::FRAME_DEPTH_DEF] = '{default: 8'h00};
    int unsigned  frame_fill    = 0;
    logic         capture_open  = 1'b0;
    logic         frame_spilled = 1'b0;
    logic         belt_running  = 1'b0;
    logic [7:0]   belt_duty     = 8'd0;
    logic [15:0]  jet_left [2]  = '{16'd0, 16'd0};
    logic [15:0]  cfg_jet_ticks = fcd_pkg::JET_TICKS_RST;
    logic [7:0]   cfg_on_speed  = fcd_pkg::ON_SPEED_RST;
    logic [7:0]   cfg_low_limit = fcd_pkg::LOW_LIMIT_RST;

    decoder_out_t pending_outcomes [$];
    logic [7:0]   body_q [$];               // frame body under construction

    // Traffic shaping
    int send_idle_pct = 27;
    int recv_idle_pct = 53;
    int tick_pct      = 0;
    logic stall_req   = 1'b0;
    int stall_left    = 0;

    // Bookkeeping
    int fault_count     = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int live_words      = 0;
    int ticks_sent      = 0;
    int frames_closed   = 0;
    logic [15:0] status_seen = '0;

    framed_command_decoder_jet_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decode model
    // ------------------------------------------------------------------

    function automatic logic ascii_digit(input logic [7:0] b);
        return (b >= fcd_pkg::CH_ZERO) && (b <= fcd_pkg::CH_NINE);
    endfunction

    // Close the open frame: verify the check digits, then run the command.
    function automatic fcd_pkg::status_t close_frame(output logic [9:0] arg);
        int unsigned body;
        int unsigned sum;
        int unsigned chk;
        int unsigned v;
        int unsigned i;
        logic        run_done;
        logic [7:0]  hi;
        logic [7:0]  lo;
        arg = '0;
        if (!capture_open) begin
            return fcd_pkg::ST_FRAME;
        end
        capture_open = 1'b0;
        if (frame_spilled || frame_fill < 3) begin
            return fcd_pkg::ST_FRAME;
        end
        body = frame_fill - 2;
        hi = frame_mem[body];
        lo = frame_mem[body + 1];
        if (!ascii_digit(hi) || !ascii_digit(lo)) begin
            return fcd_pkg::ST_CHECK;
        end
        chk = (int'(hi) - int'(fcd_pkg::CH_ZERO)) * 10
              + (int'(lo) - int'(fcd_pkg::CH_ZERO));
        sum = 0;
        for (i = 0; i < body; i++) begin
            sum += frame_mem[i];
        end
        if (sum % 100 != chk) begin
            return fcd_pkg::ST_CHECK;
        end
        // argument: digit run right after the command byte, saturated
        v = 0;
        run_done = 1'b0;
        for (i = 1; i < body; i++) begin
            if (!ascii_digit(frame_mem[i])) begin
                run_done = 1'b1;
            end
            if (!run_done) begin
                v = v * 10 + (int'(frame_mem[i]) - int'(fcd_pkg::CH_ZERO));
                if (v > 999) begin
                    v = 999;
                end
            end
        end
        arg = v[9:0];
        case (frame_mem[0])
            fcd_pkg::CH_O: begin
                belt_running = !belt_running;
                if (belt_running) begin
                    belt_duty = cfg_on_speed;
                    return fcd_pkg::ST_ON;
                end
                belt_duty = 8'd0;
                return fcd_pkg::ST_OFF;
            end
            fcd_pkg::CH_C: begin
                if (v > 255) begin
                    belt_duty = 8'd255;
                    return fcd_pkg::ST_HIGH;
                end
                belt_duty = v[7:0];
                if (v < cfg_low_limit) begin
                    return fcd_pkg::ST_LOW;
                end
                return fcd_pkg::ST_SPEED;
            end
            fcd_pkg::CH_J: begin
                if (v > 1) begin
                    return fcd_pkg::ST_BADJET;
                end
                jet_left[v] = cfg_jet_ticks;
                return fcd_pkg::ST_JET;
            end
            default: return fcd_pkg::ST_UNKNOWN;
        endcase
    endfunction

    // Advance the local state by one input word and form its result word.
    function automatic decoder_out_t decode_word(input logic is_tick, input logic [7:0] b);
        decoder_out_t r;
        logic [9:0]   arg;
        int           k;
        r.status = fcd_pkg::ST_NONE;
        arg = '0;
        if (is_tick) begin
            for (k = 0; k < 2; k++) begin
                if (jet_left[k] != 16'd0) begin
                    jet_left[k] = jet_left[k] - 16'd1;
                end
            end
        end else if (b == fcd_pkg::CH_LT) begin
            capture_open  = 1'b1;
            frame_fill    = 0;
            frame_spilled = 1'b0;
        end else if (b == fcd_pkg::CH_GT) begin
            r.status = close_frame(arg);
        end else if (capture_open) begin
            if (frame_fill < fcd_pkg::FRAME_DEPTH_DEF) begin
                frame_mem[frame_fill] = b;
                frame_fill++;
            end else begin
                frame_spilled = 1'b1;
            end
        end
        r.value = arg;
        r.belt  = belt_running;
        r.speed = belt_duty;
        r.jet0  = (jet_left[0] != 16'd0);
        r.jet1  = (jet_left[1] != 16'd0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random byte that never opens or closes a frame
    function automatic logic [7:0] plain_byte(input logic no_digits);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == fcd_pkg::CH_LT || b == fcd_pkg::CH_GT
                   || (no_digits && ascii_digit(b)));
        return b;
    endfunction

    // Offer one word, hold it until taken, and queue its expected result.
    // Called and returning at a rising edge; ready is sampled at the falling
    // edge so the decision never races the block's own updates.
    task automatic send_word(input logic is_tick, input logic [7:0] b);
        decoder_out_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_tick;
        s_tdata  <= b;
        @(negedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        // count words that do more than fall on the floor outside a frame
        if (is_tick || capture_open || b == fcd_pkg::CH_LT || b == fcd_pkg::CH_GT) begin
            live_words++;
        end
        if (is_tick) begin
            ticks_sent++;
        end else if (b == fcd_pkg::CH_GT) begin
            frames_closed++;
        end
        words_sent++;
        want = decode_word(is_tick, b);
        status_seen[want.status] = 1'b1;
        pending_outcomes.push_back(want);
        @(posedge aclk);
    endtask

    // Tick words carry random data bytes, which the block ignores
    task automatic send_tick();
        send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic tick_now_and_then();
        if ($urandom_range(0, 99) < tick_pct) begin
            send_tick();
        end
    endtask

    // Wrap body_q in markers with two check digits formed as mode says.
    task automatic send_framed(input check_mode_t mode);
        int unsigned sum;
        logic [7:0]  tens;
        logic [7:0]  ones;
        sum = 0;
        foreach (body_q[i]) begin
            sum += body_q[i];
        end
        tens = fcd_pkg::CH_ZERO + 8'((sum % 100) / 10);
        ones = fcd_pkg::CH_ZERO + 8'(sum % 10);
        if (mode == CHK_WRONG) begin
            ones = fcd_pkg::CH_ZERO + 8'((sum % 10 + $urandom_range(1, 9)) % 10);
        end else if (mode == CHK_NONDIGIT) begin
            if ($urandom_range(0, 1) != 0) begin
                tens = plain_byte(1'b1);
            end else begin
                ones = plain_byte(1'b1);
            end
        end
        send_word(1'b0, fcd_pkg::CH_LT);
        foreach (body_q[i]) begin
            tick_now_and_then();
            send_word(1'b0, body_q[i]);
        end
        send_word(1'b0, tens);
        send_word(1'b0, ones);
        tick_now_and_then();
        send_word(1'b0, fcd_pkg::CH_GT);
    endtask

    task automatic frame_text(input string text, input check_mode_t mode);
        int i;
        body_q.delete();
        for (i = 0; i < text.len(); i++) begin
            body_q.push_back(text[i]);
        end
        send_framed(mode);
    endtask

    // Drop valid, wait out every pending result, then give the block
    // time to finish any walk before a register write.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [fcd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [15:0] val);
        settle_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            fcd_pkg::CFG_JET_TICKS: cfg_jet_ticks = val;
            fcd_pkg::CFG_ON_SPEED:  cfg_on_speed  = val[7:0];
            fcd_pkg::CFG_LOW_LIMIT: cfg_low_limit = val[7:0];
            default: ;
        endcase
    endtask

    // Well-formed frame with random command and content, mostly good checks
    task automatic random_frame();
        int          pick;
        int          ndig;
        int          room;
        logic [7:0]  cmd;
        check_mode_t mode;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            cmd = fcd_pkg::CH_O;
        end else if (pick < 55) begin
            cmd = fcd_pkg::CH_C;
        end else if (pick < 85) begin
            cmd = fcd_pkg::CH_J;
        end else begin
            cmd = plain_byte(1'b0);
        end
        body_q.delete();
        body_q.push_back(cmd);
        if (cmd == fcd_pkg::CH_J && $urandom_range(0, 4) != 0) begin
            body_q.push_back(fcd_pkg::CH_ZERO + 8'($urandom_range(0, 1)));
        end else begin
            ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9)
                                               : $urandom_range(0, 3);
            repeat (ndig) body_q.push_back(fcd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        // trailing bytes after the argument end the digit run
        room = 10 - body_q.size();
        if (room > 0 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, room)) body_q.push_back(plain_byte(1'b0));
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            mode = CHK_GOOD;
        end else if (pick < 93) begin
            mode = CHK_WRONG;
        end else begin
            mode = CHK_NONDIGIT;
        end
        send_framed(mode);
    endtask

    // Broken sequences, stray markers, raw bytes and bursts of ticks
    task automatic random_noise();
        case ($urandom_range(0, 5))
            0: send_word(1'b0, fcd_pkg::CH_GT);
            1: repeat ($urandom_range(1, 4)) send_word(1'b0, 8'($urandom_range(0, 255)));
            2: begin
                send_word(1'b0, fcd_pkg::CH_LT);
                repeat (fcd_pkg::FRAME_DEPTH_DEF + $urandom_range(1, 4)) begin
                    send_word(1'b0, plain_byte(1'b0));
                end
                send_word(1'b0, fcd_pkg::CH_GT);
            end
            3: begin
                send_word(1'b0, fcd_pkg::CH_LT);
                repeat ($urandom_range(0, 2)) send_word(1'b0, plain_byte(1'b0));
                send_word(1'b0, fcd_pkg::CH_GT);
            end
            4: begin
                send_word(1'b0, fcd_pkg::CH_LT);
                repeat ($urandom_range(0, 5)) send_word(1'b0, plain_byte(1'b0));
                random_frame();
            end
            default: repeat ($urandom_range(1, 30)) send_tick();
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks with no pulse running, bytes outside a frame, a stray end marker
    task automatic test_idle_bytes();
        send_tick();
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, fcd_pkg::CH_GT);
    endtask

    // Conveyor toggle; the first frame is restarted by a second start marker
    task automatic test_conveyor();
        send_word(1'b0, fcd_pkg::CH_LT);
        send_word(1'b0, 8'h7A);
        frame_text("o", CHK_GOOD);
        frame_text("o5", CHK_GOOD);
    endtask

    // Speed command: high, low, in range, saturation, empty and cut-off runs
    task automatic test_speed();
        frame_text("c300", CHK_GOOD);
        frame_text("c7", CHK_GOOD);
        frame_text("c100", CHK_GOOD);
        frame_text("c123456789", CHK_GOOD);
        frame_text("c", CHK_GOOD);
        frame_text("c12x4", CHK_GOOD);
    endtask

    // Jet fire, countdown, retrigger and a bad jet number
    task automatic test_jets();
        frame_text("j0", CHK_GOOD);
        repeat (3) send_tick();
        frame_text("j1", CHK_GOOD);
        send_tick();
        frame_text("j0", CHK_GOOD);
        frame_text("j7", CHK_GOOD);
        frame_text("j", CHK_GOOD);
    endtask

    // Unknown commands, short and overlong frames, bad check digits
    task automatic test_frame_errors();
        body_q = '{8'hFF};
        send_framed(CHK_GOOD);
        body_q = '{8'h00, 8'h31};
        send_framed(CHK_GOOD);
        send_word(1'b0, fcd_pkg::CH_LT);
        send_word(1'b0, 8'h61);
        send_word(1'b0, 8'h62);
        send_word(1'b0, fcd_pkg::CH_GT);
        frame_text("c1234567890", CHK_GOOD);
        frame_text("c100", CHK_WRONG);
        frame_text("o", CHK_NONDIGIT);
    endtask

    // Every register at its extremes, each followed by the commands it steers
    task automatic test_config_extremes();
        write_reg(fcd_pkg::CFG_JET_TICKS, 16'd1);
        frame_text("j0", CHK_GOOD);
        repeat (2) send_tick();
        write_reg(fcd_pkg::CFG_JET_TICKS, 16'd0);
        frame_text("j1", CHK_GOOD);
        send_tick();
        write_reg(fcd_pkg::CFG_JET_TICKS, 16'hFFFF);
        frame_text("j1", CHK_GOOD);
        write_reg(fcd_pkg::CFG_ON_SPEED, 16'd0);
        frame_text("o", CHK_GOOD);
        write_reg(fcd_pkg::CFG_ON_SPEED, 16'd255);
        frame_text("o", CHK_GOOD);
        frame_text("o", CHK_GOOD);
        write_reg(fcd_pkg::CFG_LOW_LIMIT, 16'd0);
        frame_text("c0", CHK_GOOD);
        write_reg(fcd_pkg::CFG_LOW_LIMIT, 16'd255);
        frame_text("c254", CHK_GOOD);
        frame_text("c255", CHK_GOOD);
    endtask

    // Random traffic in three idling phases, new register values each time
    task automatic test_random();
        int phase;
        int goal;
        tick_pct = 20;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 53;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // short pulses so ticks can run jets back down
            write_reg(fcd_pkg::CFG_JET_TICKS, 16'($urandom_range(1, 40)));
            write_reg(fcd_pkg::CFG_ON_SPEED, 16'($urandom_range(0, 255)));
            write_reg(fcd_pkg::CFG_LOW_LIMIT, 16'($urandom_range(0, 255)));
            goal = live_words + PHASE_WORDS;
            while (live_words < goal) begin
                if ($urandom_range(0, 99) < 80) begin
                    random_frame();
                end else begin
                    random_noise();
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while frames keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req <= 1'b1;
        @(posedge aclk);
        stall_req <= 1'b0;
        repeat (10) random_frame();
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Drive ready at the rising edge; a stall request loads the hold-off count
    always @(posedge aclk) begin
        if (stall_req) begin
            stall_left <= STALL_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare one taken result word with the oldest pending expectation
    task automatic compare_outcome();
        decoder_out_t want;
        results_checked++;
        if (pending_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
                $display("result word with nothing pending: tuser %h tdata %h",
                         m_tuser, m_tdata);
            end
        end else begin
            want = pending_outcomes.pop_front();
            if (m_tuser !== want.status || m_tdata[9:0] !== want.value ||
                m_tdata[10] !== want.belt || m_tdata[18:11] !== want.speed ||
                m_tdata[19] !== want.jet0 || m_tdata[20] !== want.jet1 ||
                m_tdata[23:21] !== 3'b000) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS) begin
                    $display("result %0d: expected status %0d value %0d belt %0b pwm %0d jets %0b%0b",
                             results_checked, want.status, want.value, want.belt,
                             want.speed, want.jet1, want.jet0);
                    $display("    got status %0d value %0d belt %0b pwm %0d jets %0b%0b pad %0b",
                             m_tuser, m_tdata[9:0], m_tdata[10], m_tdata[18:11],
                             m_tdata[20], m_tdata[19], m_tdata[23:21]);
                end
            end
        end
    endtask

    // Sample at the falling edge: the word moves at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            compare_outcome();
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_bytes();
        test_conveyor();
        test_speed();
        test_jets();
        test_frame_errors();
        test_config_extremes();
        test_random();
        test_backpressure();
        settle_idle();
        // anything still pending never came out
        fault_count += pending_outcomes.size();
        $display("covered %0d words (%0d ticks, %0d frame ends), %0d result words checked",
                 words_sent, ticks_sent, frames_closed, results_checked);
        $display("status codes reached, one bit per code: %b; one %0d-cycle receiver stall",
                 status_seen[10:0], STALL_CYCLES);
        if (fault_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Hard stop if a handshake never completes
    initial begin
        #(TIMEOUT_UNITS);
        $display("testbench failed");
        $finish;
    end

endmodule
